FILE: rtl/systematic_comb_resampler_unit_defines.svh
// assertion macros for the systematic comb resampler
// used by the top level, expects clk and arst_n in scope
`ifndef SYSTEMATIC_COMB_RESAMPLER_UNIT_DEFINES_SVH
`define SYSTEMATIC_COMB_RESAMPLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define SCR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCR_ASSERT(lbl, prop, msg)
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/scr_pkg.sv
// shared widths, beat types, sequencer codes and unit interfaces
// for the systematic comb resampler; no dependencies
package scr_pkg;

	localparam int COUNT_BITS    = 20;
	localparam int FRACTION_BITS = 32;

	localparam int TAG_W      = 32;
	localparam int FRAC_W     = 32;
	localparam int CFG_W      = 21;
	localparam int START_W    = 20;
	localparam int POS_W      = COUNT_BITS + 1;
	localparam int PROD_W     = POS_W + CFG_W + 1;
	localparam int ALU_W      = PROD_W + 1;
	localparam int OPND_W     = (PROD_W > FRACTION_BITS) ? PROD_W : FRACTION_BITS;
	localparam int ITER_W     = $clog2(OPND_W);
	localparam int FRAC_SHIFT = FRAC_W - FRACTION_BITS;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BANK_TOTAL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_START  = 2'd2;

	localparam logic [CFG_W-1:0]   TARGET_RESET = CFG_W'(1024);
	localparam logic [CFG_W-1:0]   BANK_RESET   = CFG_W'(1024);
	localparam logic [START_W-1:0] START_RESET  = '0;

	typedef struct packed {
		logic              first_site;
		logic [FRAC_W-1:0] offset_fraction;
		logic [TAG_W-1:0]  site_tag;
	} in_beat_t;

	typedef struct packed {
		logic [TAG_W-1:0] out_tag;
		logic [CFG_W-1:0] copies;
	} out_beat_t;

	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_QMUL = 13'b0000000000010,
		ST_GMUL = 13'b0000000000100,
		ST_DIFF = 13'b0000000001000,
		ST_DIV  = 13'b0000000010000,
		ST_KFIX = 13'b0000000100000,
		ST_RADD = 13'b0000001000000,
		ST_KMUL = 13'b0000010000000,
		ST_LADD = 13'b0000100000000,
		ST_CMP  = 13'b0001000000000,
		ST_ADDL = 13'b0010000000000,
		ST_ADDR = 13'b0100000000000
	} step_t;

	typedef struct packed {
		logic accept;
		logic need_prep;
		logic first;
		logic neg;
		logic tooth_lt_n;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		step_t step;
		logic  last;
	} seq_ctrl_t;

	typedef struct packed {
		logic [PROD_W-1:0] x;
		logic [PROD_W-1:0] y;
		logic              inv;
		logic              cin;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] sum;
		logic             neg;
	} alu_res_t;

endpackage

FILE: rtl/scr_alu.sv
// shared add / subtract / compare unit of the comb resampler
// depends on scr_pkg
module scr_alu import scr_pkg::*; (
	input  alu_req_t req,
	output alu_res_t res
);

	logic [ALU_W-1:0] x_ext;
	logic [ALU_W-1:0] y_ext;
	logic [ALU_W-1:0] y_op;

	assign x_ext   = {1'b0, req.x};
	assign y_ext   = {1'b0, req.y};
	assign y_op    = req.inv ? ~y_ext : y_ext;
	assign res.sum = x_ext + y_op + {{(ALU_W-1){1'b0}}, req.cin};
	assign res.neg = res.sum[ALU_W-1];

endmodule

FILE: rtl/scr_seq.sv
// step sequencer and bit counter of the comb resampler
// depends on scr_pkg
module scr_seq import scr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output seq_ctrl_t   ctrl
);

	step_t             step_q;
	step_t             step_d;
	logic [ITER_W-1:0] cnt_q;
	logic [ITER_W-1:0] cnt_d;
	logic              last;

	assign last      = (cnt_q == '0);
	assign ctrl.step = step_q;
	assign ctrl.last = last;

	always_comb begin
		step_d = step_q;
		cnt_d  = cnt_q - 1'b1;
		case (step_q)
			ST_IDLE: begin
				cnt_d = ITER_W'(FRACTION_BITS - 1);
				if (status.accept) begin
					step_d = status.need_prep ? ST_QMUL : ST_CMP;
				end
			end
			ST_QMUL: begin
				if (last) begin
					step_d = ST_GMUL;
					cnt_d  = ITER_W'(POS_W - 1);
				end
			end
			ST_GMUL: begin
				if (last) begin
					step_d = status.first ? ST_DIFF : ST_RADD;
				end
			end
			ST_DIFF: begin
				cnt_d  = ITER_W'(PROD_W - 1);
				step_d = status.neg ? ST_RADD : ST_DIV;
			end
			ST_DIV: begin
				if (last) begin
					step_d = ST_KFIX;
				end
			end
			ST_KFIX: step_d = ST_RADD;
			ST_RADD: begin
				cnt_d  = ITER_W'(CFG_W - 1);
				step_d = ST_KMUL;
			end
			ST_KMUL: begin
				if (last) begin
					step_d = ST_LADD;
				end
			end
			ST_LADD: step_d = ST_CMP;
			ST_CMP: begin
				step_d = (status.neg && status.tooth_lt_n) ? ST_ADDL : ST_ADDR;
			end
			ST_ADDL: step_d = ST_CMP;
			ST_ADDR: begin
				if (status.out_free) begin
					step_d = ST_IDLE;
				end
			end
			default: step_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

FILE: rtl/systematic_comb_resampler_unit.sv
// top level of the systematic comb resampler: registers, datapath and output stage
// depends on scr_pkg, scr_alu, scr_seq and systematic_comb_resampler_unit_defines.svh
//
// channel  signals                         beat
// in       in_valid / in_ready / in_data   first_site, offset_fraction, site_tag
// out      out_valid / out_ready / out_data out_tag, copies
// cfg      cfg_we / cfg_index / cfg_data   target_count, bank_total, local_start
//
// a site that draws c copies steps through accept, one compare and one add per tooth
// on the shared adder, a final compare, then the position update
// the first site of a generation also runs the offset product, position product,
// long division if needed and tooth product; the first beat after reset or a count or
// bank write also runs the offset, position and tooth products to rebuild the bounds
// in_ready is high only while the sequencer idles; one finished result waits in the
// output register, and a full output register holds the last step of the next beat
`include "systematic_comb_resampler_unit_defines.svh"

module systematic_comb_resampler_unit import scr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0]   target_q;
	logic [CFG_W-1:0]   bank_q;
	logic [START_W-1:0] local_start_q;

	logic [POS_W-1:0]   pos_q;
	logic [CFG_W-1:0]   tooth_q;
	logic [FRAC_W-1:0]  frac_q;
	logic               stale_q;
	logic               out_valid_q;

	logic               first_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CFG_W-1:0]   copies_q;
	logic [CFG_W-1:0]   q_q;
	logic [PROD_W-1:0]  acc_q;
	logic [OPND_W-1:0]  opnd_q;
	logic [CFG_W-1:0]   rem_q;
	logic [PROD_W-1:0]  lhs_q;
	logic [PROD_W-1:0]  rhs_q;
	out_beat_t          out_q;

	seq_status_t        status;
	seq_ctrl_t          ctrl;
	alu_req_t           req;
	alu_res_t           res;

	logic               accept;
	logic               out_free;
	logic [CFG_W-1:0]   t_eff;
	logic [PROD_W-1:0]  t_ext;
	logic [PROD_W-1:0]  n_ext;
	logic [CFG_W:0]     rem2;
	logic               opnd_top;
	logic [FRAC_W-1:0]  f_src;
	logic [POS_W-1:0]   pos_next;
	logic               wrap;

	assign in_ready  = (ctrl.step == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign t_eff    = (bank_q == '0) ? CFG_W'(1) : bank_q;
	assign t_ext    = PROD_W'(t_eff);
	assign n_ext    = PROD_W'(target_q);
	assign rem2     = {rem_q, opnd_top};
	assign opnd_top = opnd_q[OPND_W-1];
	assign f_src    = in_data.first_site ? in_data.offset_fraction : frac_q;
	assign pos_next = pos_q + 1'b1;
	assign wrap     = (pos_next == '0);

	assign status.accept     = accept;
	assign status.need_prep  = in_data.first_site || stale_q;
	assign status.first      = first_q;
	assign status.neg        = res.neg;
	assign status.tooth_lt_n = (tooth_q < target_q);
	assign status.out_free   = out_free;

	scr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	scr_alu u_alu (
		.req (req),
		.res (res)
	);

	always_comb begin
		req.x   = '0;
		req.y   = '0;
		req.inv = 1'b0;
		req.cin = 1'b0;
		case (ctrl.step)
			ST_QMUL: begin
				req.x = acc_q;
				req.y = opnd_q[0] ? t_ext : '0;
			end
			ST_GMUL: begin
				req.x = acc_q << 1;
				req.y = opnd_top ? n_ext : '0;
			end
			ST_DIFF: begin
				req.x   = acc_q;
				req.y   = PROD_W'(q_q);
				req.inv = 1'b1;
			end
			ST_DIV: begin
				req.x   = PROD_W'(rem2);
				req.y   = t_ext;
				req.inv = 1'b1;
				req.cin = 1'b1;
			end
			ST_KFIX: begin
				req.x   = opnd_q[PROD_W-1:0];
				req.y   = n_ext;
				req.inv = 1'b1;
				req.cin = 1'b1;
			end
			ST_RADD: begin
				req.x = acc_q;
				req.y = n_ext;
			end
			ST_KMUL: begin
				req.x = acc_q << 1;
				req.y = opnd_top ? t_ext : '0;
			end
			ST_LADD: begin
				req.x = acc_q;
				req.y = PROD_W'(q_q);
			end
			ST_CMP: begin
				req.x   = lhs_q;
				req.y   = rhs_q;
				req.inv = 1'b1;
				req.cin = 1'b1;
			end
			ST_ADDL: begin
				req.x = lhs_q;
				req.y = t_ext;
			end
			ST_ADDR: begin
				req.x = rhs_q;
				req.y = n_ext;
			end
			default: begin
				req.x = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q      <= TARGET_RESET;
			bank_q        <= BANK_RESET;
			local_start_q <= START_RESET;
			pos_q         <= '0;
			tooth_q       <= '0;
			frac_q        <= '0;
			stale_q       <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if ((ctrl.step == ST_ADDR) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && (cfg_index inside {REG_TARGET_COUNT, REG_BANK_TOTAL})) begin
				stale_q <= 1'b1;
			end else if (ctrl.step == ST_LADD) begin
				stale_q <= 1'b0;
			end
			case (ctrl.step)
				ST_IDLE: begin
					if (accept && in_data.first_site) begin
						pos_q  <= POS_W'(local_start_q);
						frac_q <= in_data.offset_fraction;
					end
				end
				ST_DIFF: begin
					if (res.neg) begin
						tooth_q <= '0;
					end
				end
				ST_KFIX: begin
					tooth_q <= res.neg ? (opnd_q[CFG_W-1:0] + 1'b1) : target_q;
				end
				ST_ADDL: tooth_q <= tooth_q + 1'b1;
				ST_ADDR: begin
					if (out_free) begin
						pos_q <= pos_next;
					end
				end
				default: begin
					tooth_q <= tooth_q;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET_COUNT: begin
						target_q <= cfg_data;
					end
					REG_BANK_TOTAL: begin
						bank_q <= cfg_data;
					end
					REG_LOCAL_START: begin
						local_start_q <= cfg_data[START_W-1:0];
					end
					default: begin
						local_start_q <= local_start_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.step)
			ST_IDLE: begin
				if (accept) begin
					tag_q    <= in_data.site_tag;
					first_q  <= in_data.first_site;
					copies_q <= '0;
					acc_q    <= '0;
					opnd_q   <= OPND_W'(f_src >> FRAC_SHIFT);
				end
			end
			ST_QMUL: begin
				if (ctrl.last) begin
					q_q    <= res.sum[CFG_W:1];
					acc_q  <= '0;
					opnd_q <= OPND_W'(pos_q) << (OPND_W - POS_W);
				end else begin
					acc_q  <= res.sum[ALU_W-1:1];
					opnd_q <= opnd_q >> 1;
				end
			end
			ST_GMUL: begin
				acc_q  <= res.sum[PROD_W-1:0];
				opnd_q <= opnd_q << 1;
			end
			ST_DIFF: begin
				if (!res.neg) begin
					opnd_q <= OPND_W'(res.sum[PROD_W-1:0]) << (OPND_W - PROD_W);
					rem_q  <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= res.neg ? rem2[CFG_W-1:0] : res.sum[CFG_W-1:0];
				opnd_q <= {opnd_q[OPND_W-2:0], !res.neg};
			end
			ST_RADD: begin
				rhs_q  <= res.sum[PROD_W-1:0];
				acc_q  <= '0;
				opnd_q <= OPND_W'(tooth_q) << (OPND_W - CFG_W);
			end
			ST_KMUL: begin
				acc_q  <= res.sum[PROD_W-1:0];
				opnd_q <= opnd_q << 1;
			end
			ST_LADD: lhs_q <= res.sum[PROD_W-1:0];
			ST_ADDL: begin
				lhs_q    <= res.sum[PROD_W-1:0];
				copies_q <= copies_q + 1'b1;
			end
			ST_ADDR: begin
				if (out_free) begin
					rhs_q         <= wrap ? n_ext : res.sum[PROD_W-1:0];
					out_q.out_tag <= tag_q;
					out_q.copies  <= copies_q;
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	`SCR_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready after an accepted beat")
	`SCR_ASSERT(a_tooth_after_compare, (ctrl.step == ST_ADDL) |-> $past(ctrl.step == ST_CMP),
		"tooth step without a compare")
	`SCR_ASSERT_NEXT(a_result_loaded, (ctrl.step == ST_ADDR) && out_free,
		out_valid && (out_data.copies == $past(copies_q)), "result beat not loaded")

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for systematic_comb_resampler_unit: directed and random
// site streams are checked beat by beat against an exact integer comb predictor
// depends on scr_pkg and the resampler rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import scr_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = 16;
	localparam int CFG_MAX = 2**CFG_W - 1;
	localparam int START_MAX = 2**START_W - 1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid;
	logic                 in_ready;
	in_beat_t             in_data;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_beat_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// predictor copy of registers and comb state
	logic [CFG_W-1:0]   m_target;
	logic [CFG_W-1:0]   m_bank;
	logic [START_W-1:0] m_start;
	logic [POS_W-1:0]   comb_pos;
	logic [CFG_W-1:0]   comb_tooth;
	logic [FRAC_W-1:0]  comb_offset;

	out_beat_t       pending_draws[$];
	out_beat_t       due_draw;
	int              n_err = 0;
	longint unsigned cycle_count = 0;
	bit              gaps_on = 1'b1;
	int              hold_left = 0;

	systematic_comb_resampler_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// smallest tooth index whose position reaches g, clamped to [0, N]
	function automatic longint unsigned lowest_tooth_from(input longint unsigned g);
		longint unsigned n, t, f, ft, q, r, a, k;
		n = m_target;
		t = (m_bank == '0) ? 64'd1 : 64'(m_bank);
		f = 64'(comb_offset >> FRAC_SHIFT);
		ft = f * t;
		q = ft >> FRACTION_BITS;
		r = ft & ((64'd1 << FRACTION_BITS) - 64'd1);
		a = g * n;
		if (a <= q)
			return 0;
		if (r == 0)
			k = (a - q + t - 1) / t;
		else
			k = (a - q - 1) / t + 1;
		return (k > n) ? n : k;
	endfunction

	task automatic comb_site(input in_beat_t b, output out_beat_t r);
		longint unsigned hi;
		if (b.first_site) begin
			comb_pos = POS_W'(m_start);
			comb_offset = b.offset_fraction;
			comb_tooth = CFG_W'(lowest_tooth_from(64'(comb_pos)));
		end
		hi = lowest_tooth_from(64'(comb_pos) + 64'd1);
		r.out_tag = b.site_tag;
		r.copies = (hi > 64'(comb_tooth)) ? CFG_W'(hi - 64'(comb_tooth)) : '0;
		if (hi > 64'(comb_tooth))
			comb_tooth = CFG_W'(hi);
		comb_pos = comb_pos + 1'b1;
	endtask

	// receiver: random stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = !(gaps_on && $urandom_range(99) < 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_draws.size() == 0) begin
				$error("unexpected beat: out_tag %h copies %0d", out_data.out_tag,
					out_data.copies);
				n_err++;
			end else begin
				due_draw = pending_draws.pop_front();
				if (out_data.out_tag !== due_draw.out_tag) begin
					$error("out_tag expected %h actual %h", due_draw.out_tag,
						out_data.out_tag);
					n_err++;
				end
				if (out_data.copies !== due_draw.copies) begin
					$error("copies expected %0d actual %0d", due_draw.copies,
						out_data.copies);
					n_err++;
				end
			end
		end
	end

	task automatic send_site(input logic first, input logic [FRAC_W-1:0] off,
			input logic [TAG_W-1:0] tag);
		in_beat_t  b;
		out_beat_t r;
		b.first_site = first;
		b.offset_fraction = off;
		b.site_tag = tag;
		@(negedge clk);
		while (gaps_on && $urandom_range(99) < 16) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		comb_site(b, r);
		pending_draws.push_back(r);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_TARGET_COUNT: m_target = val;
			REG_BANK_TOTAL:   m_bank = val;
			REG_LOCAL_START:  m_start = val[START_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_comb(input logic [CFG_W-1:0] n, input logic [CFG_W-1:0] t,
			input logic [START_W-1:0] s);
		settle();
		write_reg(REG_TARGET_COUNT, n);
		write_reg(REG_BANK_TOTAL, t);
		write_reg(REG_LOCAL_START, CFG_W'(s));
	endtask

	task automatic test_reset_state();
		repeat (3) send_site(1'b0, $urandom, $urandom);
	endtask

	task automatic test_field_extremes();
		send_site(1'b1, '0, '0);
		send_site(1'b0, '1, '1);
		send_site(1'b1, '1, 32'h8000_0000);
		send_site(1'b1, 32'h8000_0000, 32'h0000_0001);
	endtask

	task automatic test_zero_target();
		set_comb('0, CFG_W'(16), '0);
		send_site(1'b1, $urandom, $urandom);
		send_site(1'b0, $urandom, $urandom);
	endtask

	task automatic test_zero_bank();
		set_comb(CFG_W'(3), '0, '0);
		send_site(1'b1, '0, $urandom);
		send_site(1'b0, $urandom, $urandom);
	endtask

	task automatic test_beyond_bank();
		set_comb(CFG_W'(6), CFG_W'(4), START_W'(2));
		send_site(1'b1, 32'h4000_0000, $urandom);
		repeat (4) send_site(1'b0, $urandom, $urandom);
	endtask

	task automatic test_register_extremes();
		set_comb(CFG_W'(CFG_MAX), CFG_W'(CFG_MAX), START_W'(START_MAX));
		send_site(1'b1, '1, $urandom);
		repeat (2) send_site(1'b0, $urandom, $urandom);
		set_comb(CFG_W'(1), CFG_W'(CFG_MAX), '0);
		send_site(1'b1, '0, $urandom);
		// every tooth lands on a single site
		set_comb(CFG_W'(65536), CFG_W'(1), '0);
		send_site(1'b1, '0, $urandom);
	endtask

	task automatic test_midgen_update();
		set_comb(CFG_W'(8), CFG_W'(8), '0);
		send_site(1'b1, $urandom, $urandom);
		send_site(1'b0, $urandom, $urandom);
		settle();
		write_reg(REG_TARGET_COUNT, CFG_W'(16));
		repeat (2) send_site(1'b0, $urandom, $urandom);
	endtask

	task automatic test_backpressure();
		set_comb(CFG_W'(24), CFG_W'(12), '0);
		hold_left = 400;
		send_site(1'b1, $urandom, $urandom);
		repeat (11) send_site(1'b0, $urandom, $urandom);
		settle();
	endtask

	task automatic test_random_generations(input int n_items);
		int                 left, len, t_eff, phase;
		logic [CFG_W-1:0]   t_reg, n_reg;
		logic [START_W-1:0] s_reg;
		logic [FRAC_W-1:0]  off;
		left = n_items;
		phase = 0;
		while (left > 0) begin
			if ($urandom_range(11) == 0)
				t_reg = '0;
			else if ($urandom_range(7) == 0)
				t_reg = CFG_W'($urandom_range(1, CFG_MAX));
			else
				t_reg = CFG_W'($urandom_range(1, 64));
			t_eff = (t_reg == '0) ? 1 : int'(t_reg);
			n_reg = CFG_W'($urandom_range(0, (4 * t_eff > CFG_MAX) ? CFG_MAX : 4 * t_eff));
			s_reg = START_W'($urandom_range(0,
				(t_eff + 2 > START_MAX) ? START_MAX : t_eff + 2));
			set_comb(n_reg, t_reg, s_reg);
			gaps_on = (phase == 1 || phase == 2) ? 1'b0 : ($urandom_range(4) != 0);
			repeat ($urandom_range(2, 5)) begin
				off = ($urandom_range(7) == 0) ? '1 : (($urandom_range(7) == 0) ? '0 : $urandom);
				send_site(1'b1, off, $urandom);
				len = t_eff - int'(s_reg) + 3;
				if (len > 40)
					len = 40;
				len = $urandom_range(0, len);
				for (int i = 0; i < len; i++)
					send_site($urandom_range(19) == 0, $urandom, $urandom);
				left -= len + 1;
			end
			phase++;
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_TARGET_COUNT;
		cfg_data = '0;
		m_target = TARGET_RESET;
		m_bank = BANK_RESET;
		m_start = START_RESET;
		comb_pos = '0;
		comb_tooth = '0;
		comb_offset = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_field_extremes();
		test_zero_target();
		test_zero_bank();
		test_beyond_bank();
		test_register_extremes();
		test_midgen_update();
		test_backpressure();
		test_random_generations(1710);

		settle();
		if (n_err == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
